@@ sv/bmsr_pkg.sv @@
`default_nettype none
package bmsr_pkg;
    localparam int NUM_BLOCKS_DEF = 2;
    localparam logic [15:0] RATE_RESET = 16'd200;
    localparam logic [23:0] TRANSIT_RESET = 24'd10000;

    localparam logic [1:0] OP_CHECK = 2'd0;
    localparam logic [1:0] OP_OCCUPIED = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam logic [0:0] REG_RATE = 1'b0;
    localparam logic [0:0] REG_TRANSIT = 1'b1;

    // Quotient bits of the target division; 2*200*(430*1023+28644) < 2^28.
    localparam int QW = 28;

    typedef struct packed {
        logic start;
    } t_cmd;

    typedef struct packed {
        logic done;
    } t_stat;
endpackage
`default_nettype wire

@@ sv/bmsr_ctrl.sv @@
`default_nettype none
module bmsr_ctrl
    import bmsr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    output t_cmd       o_cmd,
    input  wire t_stat i_stat
);
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_BUSY = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_BUSY;
            S_BUSY: if (i_stat.done) n_state = S_OUT;
            S_OUT:  if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_cmd.start = (r_state == S_IDLE) && i_in_valid;
endmodule
`default_nettype wire

@@ sv/bmsr_dp.sv @@
`default_nettype none
module bmsr_dp
    import bmsr_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_stat            o_stat,
    input  wire logic [15:0] i_rate,
    input  wire logic [23:0] i_max_transit,
    input  wire logic [1:0]  i_operation,
    input  wire logic        i_block_index,
    input  wire logic [31:0] i_now_ms,
    input  wire logic [9:0]  i_voltage_sample,
    input  wire logic [9:0]  i_direction_sample,
    input  wire logic [9:0]  i_supply_sample,
    output logic             o_output_enable,
    output logic             o_drive_write,
    output logic signed [9:0] o_drive_value,
    output logic             o_all_motors_zeroed,
    output logic [1:0]       o_speed_level,
    output logic [23:0]      o_transit_ms
);
    localparam int QCW = $clog2(QW + 1);

    logic [1:0]  r_level   [NUM_BLOCKS];
    logic [31:0] r_entry   [NUM_BLOCKS];
    logic [31:0] r_exit    [NUM_BLOCKS];
    logic [23:0] r_transit [NUM_BLOCKS];
    logic        r_en      [NUM_BLOCKS];
    logic signed [9:0] r_ramp [NUM_BLOCKS];
    logic [31:0] r_last    [NUM_BLOCKS];

    // Latched item
    logic [1:0]  r_op;
    logic        r_blk;
    logic        r_valid_blk;
    logic [31:0] r_now;
    logic [9:0]  r_v, r_s;
    logic        r_fwd;

    // Phases: 0 level and step product, 1 step quotient and divide setup, 2 divide, finish
    logic [2:0]  r_ph;
    logic [QCW-1:0] r_cnt;
    logic [QW-1:0]  r_num;
    logic [QW:0]    r_rem;
    logic [18:0]    r_den;
    logic [47:0]    r_prod;
    logic [9:0]     r_squo;
    logic [1:0]     r_lvl_n;
    logic           r_busy;

    logic [31:0] w_since, w_dt;
    logic [32:0] w_two;
    logic [QW:0] w_rtry;
    logic [40:0] w_recip;
    logic [9:0]  w_qd;
    logic [9:0]  w_step;
    logic [8:0]  w_tmag;
    logic signed [11:0] w_tgt, w_r, w_stp;
    logic        w_on, w_off, w_en;
    logic [31:0] w_t;
    logic [23:0] w_tclamp;

    assign w_since = r_now - r_exit[r_blk];
    assign w_dt    = r_now - r_last[r_blk];
    assign w_two   = {r_transit[r_blk], 1'b0};
    assign w_rtry  = {r_rem[QW-1:0], r_num[QW-1]};
    // Below 801000 the product divided by 1000 is exact as a multiply by
    // ceil(2^30/1000) and a shift; at or above it the step saturates at 800.
    assign w_recip = 41'(r_prod[19:0]) * 41'(21'd1073742);
    assign w_qd    = (r_prod >= 48'd801000) ? 10'd800 : w_recip[39:30];
    assign w_t     = r_now - r_entry[r_blk];
    assign w_tclamp = (w_t > {8'd0, i_max_transit}) ? i_max_transit : w_t[23:0];

    always_comb begin
        w_tmag = 9'd0;
        if (r_s != 10'd0 && r_lvl_n != 2'd0)
            w_tmag = (r_num > QW'(400)) ? 9'd400 : r_num[8:0];
        w_tgt  = r_fwd ? $signed({3'b000, w_tmag}) : -$signed({3'b000, w_tmag});
        w_step = (r_squo == 10'd0) ? 10'd1 : r_squo;
        w_stp  = $signed({2'b00, w_step});
        w_on   = (r_s >= 10'd305) && (r_v >= 10'd5);
        w_off  = !w_on && ((r_s <= 10'd237) || (r_v <= 10'd4));
        w_en   = w_on ? 1'b1 : (w_off ? 1'b0 : r_en[r_blk]);
        w_r    = w_off ? 12'sd0 : {{2{r_ramp[r_blk][9]}}, r_ramp[r_blk]};
        if (w_r < w_tgt) begin
            w_r = w_r + w_stp;
            if (w_r > w_tgt) w_r = w_tgt;
        end else if (w_r > w_tgt) begin
            w_r = w_r - w_stp;
            if (w_r < w_tgt) w_r = w_tgt;
        end
    end

    always_ff @(posedge i_clk) begin
        o_stat.done <= 1'b0;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            for (int i = 0; i < NUM_BLOCKS; i++) begin
                r_level[i] <= 2'd0; r_entry[i] <= '0; r_exit[i] <= '0;
                r_transit[i] <= '0; r_en[i] <= 1'b0; r_ramp[i] <= '0; r_last[i] <= '0;
            end
        end else if (i_cmd.start) begin
            r_op  <= i_operation;
            r_blk <= (NUM_BLOCKS > 1) ? i_block_index : 1'b0;
            r_valid_blk <= (32'(i_block_index) < 32'(NUM_BLOCKS));
            r_now <= i_now_ms; r_v <= i_voltage_sample; r_s <= i_supply_sample;
            r_fwd <= i_direction_sample > 10'd10;
            r_ph  <= 3'd0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            unique case (r_ph)
                3'd0: begin
                    r_lvl_n <= r_level[r_blk];
                    if ({1'b0, w_since} > w_two) r_lvl_n <= 2'd2;
                    else if (w_since > {8'd0, r_transit[r_blk]}) r_lvl_n <= 2'd1;
                    r_prod <= 48'(i_rate) * 48'(w_dt);
                    r_ph <= 3'd1;
                end
                3'd1: begin
                    // Numerator 200*level*(430v+28644), denominator 430s.
                    r_num <= QW'((r_lvl_n == 2'd2 ? 32'd400 : 32'd200) *
                                 (32'd430 * 32'(r_v) + 32'd28644));
                    r_den <= 19'(19'd430 * 19'(r_s));
                    r_rem <= '0; r_cnt <= QCW'(QW);
                    r_squo <= w_qd;
                    r_ph <= 3'd2;
                end
                3'd2: begin
                    // The target divide restores one quotient bit per cycle.
                    if (r_cnt != '0) begin
                        if (w_rtry >= {10'd0, r_den}) begin
                            r_rem <= w_rtry - {10'd0, r_den};
                            r_num <= {r_num[QW-2:0], 1'b1};
                        end else begin
                            r_rem <= w_rtry;
                            r_num <= {r_num[QW-2:0], 1'b0};
                        end
                        r_cnt <= r_cnt - 1'b1;
                    end
                    if (r_cnt == '0) r_ph <= 3'd3;
                end
                default: begin
                    o_output_enable <= 1'b0; o_drive_write <= 1'b0;
                    o_drive_value <= '0; o_all_motors_zeroed <= 1'b0;
                    o_speed_level <= '0; o_transit_ms <= '0;
                    if (r_valid_blk) begin
                        o_output_enable <= r_en[r_blk];
                        o_speed_level <= r_level[r_blk];
                        o_transit_ms <= r_transit[r_blk];
                        case (r_op)
                            OP_OCCUPIED: r_entry[r_blk] <= r_now;
                            OP_CLEAR: begin
                                r_level[r_blk] <= 2'd0; r_transit[r_blk] <= w_tclamp;
                                r_exit[r_blk] <= r_now;
                                o_speed_level <= 2'd0; o_transit_ms <= w_tclamp;
                            end
                            OP_CHECK: begin
                                r_level[r_blk] <= r_lvl_n;
                                o_speed_level <= r_lvl_n;
                                r_en[r_blk] <= w_en;
                                o_output_enable <= w_en;
                                o_all_motors_zeroed <= w_off;
                                if (w_off) r_ramp[r_blk] <= '0;
                                if (w_en) begin
                                    r_ramp[r_blk] <= w_r[9:0];
                                    o_drive_write <= 1'b1;
                                    o_drive_value <= w_r[9:0];
                                end
                                r_last[r_blk] <= r_now;
                            end
                            default: ;
                        endcase
                    end
                    o_stat.done <= 1'b1;
                    r_busy <= 1'b0;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

@@ sv/block_motor_speed_ramp_core.sv @@
`default_nettype none
// Flow: a level and step-product phase, a quotient and divide-setup phase, the
// 28-bit restoring divide for the target, an update phase and a registered
// hand-off of the result to the output.
// Throughput: one transaction at a time; a new input is taken only once the
// previous result has been taken, so a stalled result holds off the next input.
// Reset: synchronous active-low; registers return to 200 and 10000, all
// per-block state clears to zero.
module block_motor_speed_ramp_core
    import bmsr_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_operation,
    input  wire logic        i_block_index,
    input  wire logic [31:0] i_now_ms,
    input  wire logic [9:0]  i_voltage_sample,
    input  wire logic [9:0]  i_direction_sample,
    input  wire logic [9:0]  i_supply_sample,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_output_enable,
    output logic             o_drive_write,
    output logic signed [9:0] o_drive_value,
    output logic             o_all_motors_zeroed,
    output logic [1:0]       o_speed_level,
    output logic [23:0]      o_transit_ms
);
    logic [15:0] r_rate;
    logic [23:0] r_max_transit;
    t_cmd  w_cmd;
    t_stat w_stat;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_RESET;
            r_max_transit <= TRANSIT_RESET;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
            if (paddr[2] == REG_RATE) r_rate <= pwdata[15:0];
            else r_max_transit <= pwdata[23:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            unique case (paddr[2])
                REG_RATE:    prdata = {16'd0, r_rate};
                REG_TRANSIT: prdata = {8'd0, r_max_transit};
                default:     prdata = '0;
            endcase
        end
    end

    bmsr_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid, .i_out_ready,
        .o_cmd(w_cmd), .i_stat(w_stat)
    );

    bmsr_dp #(.NUM_BLOCKS(NUM_BLOCKS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_stat(w_stat),
        .i_rate(r_rate), .i_max_transit(r_max_transit),
        .i_operation, .i_block_index, .i_now_ms, .i_voltage_sample,
        .i_direction_sample, .i_supply_sample,
        .o_output_enable, .o_drive_write, .o_drive_value, .o_all_motors_zeroed,
        .o_speed_level, .o_transit_ms
    );
endmodule
`default_nettype wire

@@ verif/block_motor_speed_ramp_core_checker.sv @@
`default_nettype none
module block_motor_speed_ramp_core_checker
    import bmsr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    input  wire logic        i_in_valid,
    input  wire logic        o_in_ready,
    input  wire logic [1:0]  i_operation,
    input  wire logic        i_block_index,
    input  wire logic [31:0] i_now_ms,
    input  wire logic [9:0]  i_voltage_sample,
    input  wire logic [9:0]  i_direction_sample,
    input  wire logic [9:0]  i_supply_sample,
    input  wire logic        o_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic        o_output_enable,
    input  wire logic        o_drive_write,
    input  wire logic signed [9:0] o_drive_value,
    input  wire logic        o_all_motors_zeroed,
    input  wire logic [1:0]  o_speed_level,
    input  wire logic [23:0] o_transit_ms,
    output int               o_errors,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        enable;
        logic        wrote;
        logic [9:0]  drive;
        logic        zeroed;
        logic [1:0]  level;
        logic [23:0] transit;
    } t_status;

    t_status motor_status_q[$];

    logic [15:0] rate;
    logic [23:0] transit_cap;
    logic [1:0]  level_st [2];
    logic [31:0] entry_t [2];
    logic [31:0] exit_t [2];
    logic [23:0] transit_t [2];
    logic        enable_st [2];
    int          ramp_st [2];
    logic [31:0] last_chk [2];

    function automatic int drive_target(logic [1:0] lvl, logic [9:0] v, logic [9:0] d,
                                        logic [9:0] s);
        longint unsigned num, den, q;
        if (s == 0 || lvl == 0) return 0;
        num = 64'd200 * lvl * (64'd430 * v + 64'd28644);
        den = 64'd430 * s;
        q = num / den;
        if (q > 400) q = 400;
        return (d > 10) ? int'(q) : -int'(q);
    endfunction

    function automatic t_status predict_motor(logic [1:0] op, logic b, logic [31:0] now,
                                              logic [9:0] v, logic [9:0] d, logic [9:0] s);
        t_status r;
        logic [31:0] t, since, dt;
        longint unsigned step;
        int tgt, x;
        r = '0;
        if (op == OP_OCCUPIED) begin
            entry_t[b] = now;
        end else if (op == OP_CLEAR) begin
            t = now - entry_t[b];
            level_st[b] = 0;
            if (t > {8'd0, transit_cap}) t = {8'd0, transit_cap};
            transit_t[b] = t[23:0];
            exit_t[b] = now;
        end else if (op == OP_CHECK) begin
            since = now - exit_t[b];
            if (64'(since) > 64'd2 * transit_t[b]) level_st[b] = 2;
            else if (since > {8'd0, transit_t[b]}) level_st[b] = 1;
            tgt = drive_target(level_st[b], v, d, s);
            if (s >= 305 && v >= 5) begin
                enable_st[b] = 1;
            end else if (s <= 237 || v <= 4) begin
                enable_st[b] = 0;
                ramp_st[b] = 0;
                r.zeroed = 1;
            end
            dt = now - last_chk[b];
            step = 64'(rate) * 64'(dt) / 1000;
            if (step == 0) step = 1;
            if (step > 800) step = 800;
            if (enable_st[b]) begin
                x = ramp_st[b];
                if (x < tgt) begin
                    x += int'(step);
                    if (x > tgt) x = tgt;
                end else if (x > tgt) begin
                    x -= int'(step);
                    if (x < tgt) x = tgt;
                end
                ramp_st[b] = x;
                r.wrote = 1;
                r.drive = x[9:0];
            end
            last_chk[b] = now;
        end
        r.enable = enable_st[b];
        r.level = level_st[b];
        r.transit = transit_t[b];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
    end

    assign o_pending = motor_status_q.size();

    always @(posedge i_clk) begin
        t_status e;
        if (!i_rst_n) begin
            rate <= RATE_RESET;
            transit_cap <= TRANSIT_RESET;
            for (int i = 0; i < 2; i++) begin
                level_st[i] = 0; entry_t[i] = 0; exit_t[i] = 0; transit_t[i] = 0;
                enable_st[i] = 0; ramp_st[i] = 0; last_chk[i] = 0;
            end
            motor_status_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_RATE) rate <= pwdata[15:0];
                else transit_cap <= pwdata[23:0];
            end
            if (i_in_valid && o_in_ready)
                motor_status_q.push_back(predict_motor(i_operation, i_block_index, i_now_ms,
                    i_voltage_sample, i_direction_sample, i_supply_sample));
            if (o_out_valid && i_out_ready) begin
                if (motor_status_q.size() == 0) begin
                    report_mismatch("unexpected transaction", 1, 0);
                end else begin
                    e = motor_status_q.pop_front();
                    if (o_output_enable !== e.enable)
                        report_mismatch("output_enable", o_output_enable, e.enable);
                    if (o_drive_write !== e.wrote)
                        report_mismatch("drive_write", o_drive_write, e.wrote);
                    if (o_drive_value !== e.drive)
                        report_mismatch("drive_value", o_drive_value, $signed(e.drive));
                    if (o_all_motors_zeroed !== e.zeroed)
                        report_mismatch("all_motors_zeroed", o_all_motors_zeroed, e.zeroed);
                    if (o_speed_level !== e.level)
                        report_mismatch("speed_level", o_speed_level, e.level);
                    if (o_transit_ms !== e.transit)
                        report_mismatch("transit_ms", o_transit_ms, e.transit);
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ verif/block_motor_speed_ramp_core_tb.sv @@
`default_nettype none
module block_motor_speed_ramp_core_tb;
    import bmsr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [2:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 0;
    logic        o_in_ready;
    logic [1:0]  i_operation = 0;
    logic        i_block_index = 0;
    logic [31:0] i_now_ms = 0;
    logic [9:0]  i_voltage_sample = 0, i_direction_sample = 0, i_supply_sample = 0;
    logic        o_out_valid;
    logic        i_out_ready = 0;
    logic        o_output_enable, o_drive_write, o_all_motors_zeroed;
    logic signed [9:0] o_drive_value;
    logic [1:0]  o_speed_level;
    logic [23:0] o_transit_ms;
    int          errors, pending;
    bit          calm = 0;
    logic [31:0] clock_ms [2];

    always #2 i_clk = ~i_clk;

    block_motor_speed_ramp_core dut (.*);
    block_motor_speed_ramp_core_checker checker_i (.*, .o_errors(errors), .o_pending(pending));

    // The receiver stalls at random except during the calm stretch.
    always @(posedge i_clk) i_out_ready <= calm || ($urandom_range(99) >= 22);

    task automatic write_reg(logic [0:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic drain();
        i_in_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    // Valid stays high after an accepted transaction so that the next one can
    // follow at once; an idle gap or drain() lowers it.
    task automatic send_item(logic [1:0] op, logic b, logic [31:0] now,
                             logic [9:0] v, logic [9:0] d, logic [9:0] s);
        if (!calm && $urandom_range(99) < 22) begin
            i_in_valid <= 0;
            do @(posedge i_clk); while ($urandom_range(99) < 22);
        end
        i_in_valid <= 1; i_operation <= op; i_block_index <= b; i_now_ms <= now;
        i_voltage_sample <= v; i_direction_sample <= d; i_supply_sample <= s;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Mostly well-formed occupy/clear/check sequences on a moving clock.
    task automatic random_item();
        logic b;
        int k;
        logic [9:0] v, s;
        b = 1'($urandom_range(1));
        k = $urandom_range(99);
        clock_ms[b] += ($urandom_range(9) == 0) ? $urandom : $urandom_range(3000);
        v = ($urandom_range(4) == 0) ? 10'($urandom) : 10'($urandom_range(1023, 5));
        s = ($urandom_range(4) == 0) ? 10'($urandom) : 10'($urandom_range(1023, 240));
        if (k < 10)
            send_item(OP_OCCUPIED, b, clock_ms[b], 10'($urandom), 10'($urandom),
                      10'($urandom));
        else if (k < 20)
            send_item(OP_CLEAR, b, clock_ms[b], 10'($urandom), 10'($urandom),
                      10'($urandom));
        else if (k < 23)
            send_item(OP_RESERVED, b, $urandom, 10'($urandom), 10'($urandom),
                      10'($urandom));
        else send_item(OP_CHECK, b, clock_ms[b], v, 10'($urandom), s);
    endtask

    initial begin
        #1ms;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        clock_ms[0] = 0; clock_ms[1] = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        // Directed: extremes, all operations, cutoff, hysteresis dead band.
        send_item(OP_CHECK, 0, 0, 0, 0, 0);
        send_item(OP_OCCUPIED, 0, 100, 1023, 1023, 1023);
        send_item(OP_CLEAR, 0, 600, 0, 0, 0);
        send_item(OP_CHECK, 0, 1200, 1023, 1023, 305);
        send_item(OP_CHECK, 0, 1800, 1023, 1023, 305);
        send_item(OP_CHECK, 0, 32'hFFFF_FFFF, 5, 11, 1023);
        send_item(OP_CHECK, 0, 32'hFFFF_FFFF, 1023, 10, 1);
        send_item(OP_CHECK, 0, 32'h0000_1000, 1023, 0, 250);
        send_item(OP_CHECK, 0, 32'h0000_2000, 4, 1023, 1023);
        send_item(OP_CHECK, 0, 32'h0000_3000, 1023, 1023, 237);
        send_item(OP_OCCUPIED, 1, 32'hFFFF_FF00, 0, 0, 0);
        send_item(OP_CLEAR, 1, 32'h7FFF_0000, 0, 0, 0);
        send_item(OP_CHECK, 1, 32'h8000_0000, 600, 500, 400);
        send_item(OP_RESERVED, 1, 32'hFFFF_FFFF, 1023, 1023, 1023);
        send_item(OP_CHECK, 1, 32'hFFFF_FFFF, 1023, 1023, 1023);
        clock_ms[0] = 32'h3000; clock_ms[1] = 32'hFFFF_FFFF;
        drain();
        write_reg(REG_RATE, 32'hFFFF);
        write_reg(REG_TRANSIT, 32'h00FF_FFFF);
        for (int ph = 0; ph < 5; ph++) begin
            calm = (ph == 2);
            repeat (170) random_item();
            drain();
            case (ph)
                0: begin write_reg(REG_RATE, 0); write_reg(REG_TRANSIT, 0); end
                1: begin write_reg(REG_RATE, 1); write_reg(REG_TRANSIT, 500); end
                2: begin write_reg(REG_RATE, $urandom); write_reg(REG_TRANSIT, $urandom); end
                default: begin write_reg(REG_RATE, 200); write_reg(REG_TRANSIT, 10000); end
            endcase
        end
        drain();
        if (errors == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire
